// File: rtl/nidas_pkg.sv
// shared types and constants of the node id allocation server
// no dependencies

package nidas_pkg;

	localparam int TABLE_ENTRIES_DEF = 128;
	localparam int ID_BYTES = 16;
	localparam int ID_W = ID_BYTES * 8;
	localparam int NODE_W = 7;
	localparam int CHUNK_W = 48;
	localparam int LEN_W = 5;

	localparam logic [NODE_W-1:0] LOWEST_RST = 7'd11;
	localparam logic [NODE_W-1:0] HIGHEST_RST = 7'd125;

	localparam logic [LEN_W-1:0] LEN_PART1 = 5'd6;
	localparam logic [LEN_W-1:0] LEN_PART2 = 5'd12;
	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(ID_BYTES);

	localparam logic REG_LOWEST = 1'b0;
	localparam logic REG_HIGHEST = 1'b1;

	typedef struct packed {
		logic go;
		logic [NODE_W-1:0] lowest;
		logic [NODE_W-1:0] top;
	} srch_req_t;

	typedef struct packed {
		logic done;
		logic [NODE_W-1:0] node_id;
	} srch_rsp_t;

endpackage

// File: rtl/node_id_allocation_server_top.sv
// node id allocation server top: request handshake, id assembly, config
// depends on nidas_pkg and nidas_search
//
// usage:
//   requests enter on start/first_part/chunk_bytes/requested_node_id and
//   are taken at a clock edge with start high and busy low.
//   results leave on done plus echo_length, reply_node_id, echo_id_low and
//   echo_id_high, valid for the single cycle that done is high; the
//   receiver has no way to stall them.
//   first and second part requests answer in the cycle after acceptance and
//   may follow back to back. a wrong kind of request resets the handshake
//   and gives no word.
//   the third part starts a table search and holds busy high through the
//   match scan over the ids in range (one compare a cycle on the
//   registered id store read), the free scan and the registering of the
//   word.
//   configuration is written through cfg_we/cfg_addr/cfg_wdata with no
//   wait state; the user must write it only while idle, the block does not enforce it.
//   reset clears the handshake, the assembled id and every occupancy flag
//   at once; the id store needs no clearing pass.

module node_id_allocation_server_top
	import nidas_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_addr,
	input  logic [NODE_W-1:0]   cfg_wdata,
	input  logic                start,
	output logic                busy,
	input  logic                first_part,
	input  logic [CHUNK_W-1:0]  chunk_bytes,
	input  logic [NODE_W-1:0]   requested_node_id,
	output logic                done,
	output logic [LEN_W-1:0]    echo_length,
	output logic [NODE_W-1:0]   reply_node_id,
	output logic [63:0]         echo_id_low,
	output logic [63:0]         echo_id_high
);

	localparam logic [NODE_W-1:0] TOP_MAX = NODE_W'(TABLE_ENTRIES - 1);

	typedef enum logic [1:0] {
		STG_FIRST,
		STG_SECOND,
		STG_THIRD
	} stage_t;

	stage_t stage_q;
	logic [NODE_W-1:0] lowest_q;
	logic [NODE_W-1:0] highest_q;
	logic [63:0] asm_lo_q;
	logic [63:0] asm_hi_q;
	logic busy_q;
	logic done_q;
	logic [LEN_W-1:0] len_q;
	logic [NODE_W-1:0] reply_q;
	logic [63:0] echo_lo_q;
	logic [63:0] echo_hi_q;

	logic accept;
	logic [63:0] part2_lo;
	logic [63:0] part2_hi;
	srch_req_t srch_req;
	srch_rsp_t srch_rsp;

	assign accept = start && !busy_q;
	assign part2_lo = {chunk_bytes[15:0], asm_lo_q[47:0]};
	assign part2_hi = 64'(chunk_bytes[47:16]);

	assign srch_req.go = accept && (stage_q == STG_THIRD) && !first_part;
	assign srch_req.lowest = lowest_q;
	assign srch_req.top = (highest_q > TOP_MAX) ? TOP_MAX : highest_q;

	nidas_search #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (srch_req),
		.id_word({asm_hi_q, asm_lo_q}),
		.rsp    (srch_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q <= LOWEST_RST;
			highest_q <= HIGHEST_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LOWEST:  lowest_q <= cfg_wdata;
				REG_HIGHEST: highest_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= STG_FIRST;
			asm_lo_q <= '0;
			asm_hi_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (srch_rsp.done) begin
				done_q <= 1'b1;
				busy_q <= 1'b0;
				len_q <= LEN_FULL;
				reply_q <= srch_rsp.node_id;
				echo_lo_q <= asm_lo_q;
				echo_hi_q <= asm_hi_q;
			end
			if (accept) begin
				case (stage_q)
					STG_FIRST: begin
						if (first_part) begin
							stage_q <= STG_SECOND;
							asm_lo_q <= 64'(chunk_bytes);
							asm_hi_q <= '0;
							done_q <= 1'b1;
							len_q <= LEN_PART1;
							reply_q <= requested_node_id;
							echo_lo_q <= 64'(chunk_bytes);
							echo_hi_q <= '0;
						end else begin
							stage_q <= STG_FIRST;
						end
					end
					STG_SECOND: begin
						if (first_part) begin
							stage_q <= STG_FIRST;
						end else begin
							stage_q <= STG_THIRD;
							asm_lo_q <= part2_lo;
							asm_hi_q <= part2_hi;
							done_q <= 1'b1;
							len_q <= LEN_PART2;
							reply_q <= requested_node_id;
							echo_lo_q <= part2_lo;
							echo_hi_q <= part2_hi;
						end
					end
					STG_THIRD: begin
						stage_q <= STG_FIRST;
						if (!first_part) begin
							asm_hi_q <= {chunk_bytes[31:0], asm_hi_q[31:0]};
							busy_q <= 1'b1;
						end
					end
					default: begin
						stage_q <= STG_FIRST;
					end
				endcase
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign echo_length = len_q;
	assign reply_node_id = reply_q;
	assign echo_id_low = echo_lo_q;
	assign echo_id_high = echo_hi_q;

endmodule

// File: rtl/nidas_idmem.sv
// unique id store of the allocation table, one 16-byte id per entry
// depends on nidas_pkg

module nidas_idmem
	import nidas_pkg::*;
#(
	parameter int DEPTH = TABLE_ENTRIES_DEF,
	parameter int AW = $clog2(TABLE_ENTRIES_DEF)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [ID_W-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [ID_W-1:0] rd_data
);

	logic [ID_W-1:0] mem_q [DEPTH];
	logic [ID_W-1:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_s1;

endmodule

// File: rtl/nidas_search.sv
// table search sequencer: occupancy flags, one shared id comparator,
// match scan then free scan; depends on nidas_pkg and nidas_idmem

module nidas_search
	import nidas_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  srch_req_t       req,
	input  logic [ID_W-1:0] id_word,
	output srch_rsp_t       rsp
);

	localparam int IW = $clog2(TABLE_ENTRIES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_FREE
	} state_t;

	state_t state_q;
	logic [TABLE_ENTRIES-1:0] occ_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] top_q;
	logic [NODE_W-1:0] lowest_q;
	logic [NODE_W-1:0] node_q;
	logic done_q;
	logic cmp_vld_s1;
	logic occ_s1;
	logic [IW-1:0] idx_s1;

	logic in_range;
	logic id_eq;
	logic wr_en;
	logic [ID_W-1:0] rd_data;

	assign in_range = NODE_W'(idx_q) > lowest_q;
	assign id_eq = rd_data == id_word;
	assign wr_en = (state_q == S_FREE) && in_range && !occ_q[idx_q];

	nidas_idmem #(
		.DEPTH(TABLE_ENTRIES),
		.AW   (IW)
	) u_idmem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(idx_q),
		.wr_data(id_word),
		.rd_addr(idx_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q <= '0;
			done_q <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.go) begin
						lowest_q <= req.lowest;
						idx_q <= req.top[IW-1:0];
						top_q <= req.top[IW-1:0];
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					// read data is registered and lags the address
					if (cmp_vld_s1 && occ_s1 && id_eq) begin
						node_q <= NODE_W'(idx_s1);
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (in_range) begin
						cmp_vld_s1 <= 1'b1;
						idx_s1 <= idx_q;
						occ_s1 <= occ_q[idx_q];
						idx_q <= idx_q - 1'b1;
					end else if (!cmp_vld_s1) begin
						idx_q <= top_q;
						state_q <= S_FREE;
					end
				end
				S_FREE: begin
					if (in_range) begin
						if (!occ_q[idx_q]) begin
							occ_q[idx_q] <= 1'b1;
							node_q <= NODE_W'(idx_q);
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end else begin
						// table full
						node_q <= '0;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.node_id = node_q;

endmodule

// File: rtl/nidas_checker.sv
// port level checks of the node id allocation server and their bind
// depends on nidas_pkg and node_id_allocation_server_top

module nidas_checker
	import nidas_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [NODE_W-1:0]  requested_node_id,
	input logic               done,
	input logic [LEN_W-1:0]   echo_length,
	input logic [NODE_W-1:0]  reply_node_id,
	input logic [63:0]        echo_id_high
);

	// a word only follows an accepted request or an ongoing search
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result word without a request");

	// no word while the search still runs
	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result word while busy");

	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	// early stages echo the node id of the request in the cycle before
	a_early_echo: assert property (@(posedge clk) disable iff (!arst_n)
		done && (echo_length == LEN_PART1 || echo_length == LEN_PART2)
			|-> reply_node_id == $past(requested_node_id))
		else $error("early stage reply does not echo the node id");

	a_first_high: assert property (@(posedge clk) disable iff (!arst_n)
		done && echo_length == LEN_PART1 |-> echo_id_high == '0)
		else $error("first stage echo has high bytes set");

endmodule

bind node_id_allocation_server_top nidas_checker u_nidas_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.requested_node_id(requested_node_id),
	.done             (done),
	.echo_length      (echo_length),
	.reply_node_id    (reply_node_id),
	.echo_id_high     (echo_id_high)
);

// File: tb/tb_node_id_allocation_server_top.sv
`timescale 1ns / 100ps
// testbench of node_id_allocation_server_top: directed request table, then random handshakes
// every reply word is checked against its directed typed value or an in-bench model of the handshake and id table
// depends on nidas_pkg and node_id_allocation_server_top

module tb_node_id_allocation_server_top;
	import nidas_pkg::*;

	localparam int ENTRIES = TABLE_ENTRIES_DEF;
	localparam int SEARCH_CYCLES = 2 * ENTRIES + 8;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTINGS_PER_PHASE = 4;
	localparam int REQS_PER_SETTING = 150;

	typedef enum logic [1:0] {WAIT_FIRST, WAIT_SECOND, WAIT_THIRD, STAGE_SPARE} stage_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_t;
	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		logic [LEN_W-1:0]  len;
		logic [NODE_W-1:0] node;
		logic [63:0]       lo;
		logic [63:0]       hi;
	} echo_t;

	typedef struct {
		row_kind_t          kind;
		logic               addr;
		logic [NODE_W-1:0]  val;
		logic               fp;
		logic [CHUNK_W-1:0] chunk;
		logic [NODE_W-1:0]  req;
		chk_t               chk;
		echo_t              typed;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_addr;
	logic [NODE_W-1:0]  cfg_wdata;
	logic               start;
	logic               busy;
	logic               first_part;
	logic [CHUNK_W-1:0] chunk_bytes;
	logic [NODE_W-1:0]  requested_node_id;
	logic               done;
	logic [LEN_W-1:0]   echo_length;
	logic [NODE_W-1:0]  reply_node_id;
	logic [63:0]        echo_id_low;
	logic [63:0]        echo_id_high;

	// model of the handshake and the id table
	stage_t            hs_stage;
	logic [63:0]       id_lo;
	logic [63:0]       id_hi;
	bit                occupied [ENTRIES];
	logic [63:0]       held_lo [ENTRIES];
	logic [63:0]       held_hi [ENTRIES];
	logic [NODE_W-1:0] cfg_lowest;
	logic [NODE_W-1:0] cfg_highest;

	echo_t       replies_due [$];
	echo_t       no_echo;
	stim_row_t   directed [$];
	logic [127:0] known_ids [$];
	int          mismatches;
	int          idle_pct;

	node_id_allocation_server_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [NODE_W-1:0] claim_node();
		int top;
		int i;
		top = (int'(cfg_highest) > ENTRIES - 1) ? ENTRIES - 1 : int'(cfg_highest);
		for (i = top; i > int'(cfg_lowest); i--)
			if (occupied[i] && held_lo[i] == id_lo && held_hi[i] == id_hi)
				return NODE_W'(i);
		for (i = top; i > int'(cfg_lowest); i--)
			if (!occupied[i]) begin
				occupied[i] = 1'b1;
				held_lo[i] = id_lo;
				held_hi[i] = id_hi;
				return NODE_W'(i);
			end
		return '0;
	endfunction

	function automatic bit serve_request(input logic fp, input logic [CHUNK_W-1:0] ch,
			input logic [NODE_W-1:0] rq, output echo_t rep);
		rep = '{default: '0};
		case (hs_stage)
			WAIT_FIRST: begin
				if (!fp)
					return 1'b0;
				hs_stage = WAIT_SECOND;
				id_lo = 64'(ch);
				id_hi = '0;
				rep = '{LEN_PART1, rq, id_lo, 64'd0};
				return 1'b1;
			end
			WAIT_SECOND: begin
				if (fp) begin
					hs_stage = WAIT_FIRST;
					return 1'b0;
				end
				hs_stage = WAIT_THIRD;
				id_lo = {ch[15:0], id_lo[47:0]};
				id_hi = {32'd0, ch[47:16]};
				rep = '{LEN_PART2, rq, id_lo, id_hi};
				return 1'b1;
			end
			WAIT_THIRD: begin
				hs_stage = WAIT_FIRST;
				if (fp)
					return 1'b0;
				// only the low four bytes of the last part count
				id_hi = {ch[31:0], id_hi[31:0]};
				rep.len = LEN_FULL;
				rep.node = claim_node();
				rep.lo = id_lo;
				rep.hi = id_hi;
				return 1'b1;
			end
			default: begin
				hs_stage = WAIT_FIRST;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic stim_row_t req_row(input logic fp, input logic [CHUNK_W-1:0] ch,
			input logic [NODE_W-1:0] rq, input chk_t chk, input echo_t typed);
		stim_row_t r;
		r = '{ROW_REQ, REG_LOWEST, '0, fp, ch, rq, chk, typed};
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic addr, input logic [NODE_W-1:0] val);
		stim_row_t r;
		r = '{ROW_CFG, addr, val, 1'b0, '0, '0, CHK_NONE, no_echo};
		return r;
	endfunction

	function automatic logic [CHUNK_W-1:0] rand_chunk();
		return CHUNK_W'({$urandom, $urandom});
	endfunction

	function automatic logic [NODE_W-1:0] rand_node();
		return NODE_W'($urandom_range(127));
	endfunction

	// zero and all-ones bytes are common so that near misses hide behind them
	function automatic logic [127:0] fresh_id();
		logic [127:0] v;
		int b;
		int r;
		for (b = 0; b < ID_BYTES; b++) begin
			r = $urandom_range(99);
			v[8*b +: 8] = (r < 25) ? 8'h00 : (r < 35) ? 8'hff : 8'($urandom);
		end
		return v;
	endfunction

	// called just after a falling edge; returns just after a falling edge with start still high
	task automatic send_req(input logic fp, input logic [CHUNK_W-1:0] ch,
			input logic [NODE_W-1:0] rq, input chk_t chk, input echo_t typed);
		echo_t rep;
		bit has;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		first_part <= fp;
		chunk_bytes <= ch;
		requested_node_id <= rq;
		do @(posedge clk); while (busy);
		has = serve_request(fp, ch, rq, rep);
		if (chk == CHK_TYPED)
			replies_due.push_back(typed);
		else if (chk == CHK_MODEL && has)
			replies_due.push_back(rep);
		@(negedge clk);
	endtask

	// sender holds off until every reply word is in and a full search could have ended
	task automatic settle();
		start <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (SEARCH_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic addr, input logic [NODE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		if (addr == REG_LOWEST)
			cfg_lowest = val;
		else
			cfg_highest = val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_handshake(input logic [127:0] uid, input int parts);
		logic [CHUNK_W-1:0] last_part;
		last_part = {16'($urandom), uid[127:96]};
		send_req(1'b1, uid[47:0], rand_node(), CHK_MODEL, no_echo);
		if (parts > 1)
			send_req(1'b0, uid[95:48], rand_node(), CHK_MODEL, no_echo);
		if (parts > 2)
			send_req(1'b0, last_part, rand_node(), CHK_MODEL, no_echo);
		else
			send_req(1'b1, rand_chunk(), rand_node(), CHK_MODEL, no_echo);
	endtask

	always @(posedge clk) begin
		echo_t want;
		if (arst_n && done === 1'b1) begin
			if (replies_due.size() == 0) begin
				$error("reply word with none expected: echo_length %0d reply_node_id %0d",
					echo_length, reply_node_id);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				if (echo_length !== want.len) begin
					$error("echo_length: expected %0d, got %0d", want.len, echo_length);
					mismatches++;
				end
				if (reply_node_id !== want.node) begin
					$error("reply_node_id: expected %0d, got %0d", want.node, reply_node_id);
					mismatches++;
				end
				if (echo_id_low !== want.lo) begin
					$error("echo_id_low: expected %h, got %h", want.lo, echo_id_low);
					mismatches++;
				end
				if (echo_id_high !== want.hi) begin
					$error("echo_id_high: expected %h, got %h", want.hi, echo_id_high);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL node_id_allocation_server_top");
		$finish;
	end

	initial begin
		int phase;
		int s;
		int sent;
		int r;
		int parts;
		int flip;
		logic [127:0] uid;
		logic [NODE_W-1:0] lo_v;
		logic [NODE_W-1:0] hi_v;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_LOWEST;
		cfg_wdata = '0;
		start = 1'b0;
		first_part = 1'b0;
		chunk_bytes = '0;
		requested_node_id = '0;
		mismatches = 0;
		idle_pct = 16;
		no_echo = '{default: '0};

		hs_stage = WAIT_FIRST;
		id_lo = '0;
		id_hi = '0;
		foreach (occupied[k])
			occupied[k] = 1'b0;
		cfg_lowest = LOWEST_RST;
		cfg_highest = HIGHEST_RST;

		// later part while waiting for the first, then extremes of every field
		directed.push_back(req_row(1'b0, 48'h1234_5678_9abc, 7'd5, CHK_NONE, no_echo));
		directed.push_back(req_row(1'b1, '1, 7'd127, CHK_TYPED,
			'{LEN_PART1, 7'd127, 64'h0000_ffff_ffff_ffff, 64'd0}));
		// first part again mid handshake drops it
		directed.push_back(req_row(1'b1, 48'h0, 7'd0, CHK_NONE, no_echo));
		directed.push_back(req_row(1'b1, 48'h0, 7'd0, CHK_TYPED,
			'{LEN_PART1, 7'd0, 64'd0, 64'd0}));
		directed.push_back(req_row(1'b0, '1, 7'd127, CHK_TYPED,
			'{LEN_PART2, 7'd127, 64'hffff_0000_0000_0000, 64'h0000_0000_ffff_ffff}));
		directed.push_back(req_row(1'b0, '1, 7'd0, CHK_TYPED,
			'{LEN_FULL, 7'd125, 64'hffff_0000_0000_0000, '1}));
		// same id again, upper bytes of the last part differ but are ignored
		directed.push_back(req_row(1'b1, 48'h0, 7'd3, CHK_MODEL, no_echo));
		directed.push_back(req_row(1'b0, '1, 7'd9, CHK_MODEL, no_echo));
		directed.push_back(req_row(1'b0, 48'h0000_ffff_ffff, 7'd64, CHK_MODEL, no_echo));
		// first part in place of the third, then a later part while waiting for the first
		directed.push_back(req_row(1'b1, 48'h0102_0304_0506, 7'd1, CHK_MODEL, no_echo));
		directed.push_back(req_row(1'b0, 48'h0708_090a_0b0c, 7'd2, CHK_MODEL, no_echo));
		directed.push_back(req_row(1'b1, 48'ha5a5_a5a5_a5a5, 7'd3, CHK_NONE, no_echo));
		directed.push_back(req_row(1'b0, 48'h0d0e_0f10_1112, 7'd4, CHK_NONE, no_echo));
		// empty search range: table reads as full
		directed.push_back(cfg_row(REG_LOWEST, 7'd127));
		directed.push_back(req_row(1'b1, 48'h0, 7'd10, CHK_TYPED,
			'{LEN_PART1, 7'd10, 64'd0, 64'd0}));
		directed.push_back(req_row(1'b0, 48'h0, 7'd20, CHK_TYPED,
			'{LEN_PART2, 7'd20, 64'd0, 64'd0}));
		directed.push_back(req_row(1'b0, 48'h0, 7'd30, CHK_TYPED,
			'{LEN_FULL, 7'd0, 64'd0, 64'd0}));
		// widest range
		directed.push_back(cfg_row(REG_LOWEST, 7'd0));
		directed.push_back(cfg_row(REG_HIGHEST, 7'd127));
		directed.push_back(req_row(1'b1, 48'h0, 7'd40, CHK_MODEL, no_echo));
		directed.push_back(req_row(1'b0, 48'h0, 7'd50, CHK_MODEL, no_echo));
		directed.push_back(req_row(1'b0, 48'h0, 7'd60, CHK_MODEL, no_echo));
		// single id in range; second id differs only after zero bytes
		directed.push_back(cfg_row(REG_HIGHEST, 7'd1));
		directed.push_back(req_row(1'b1, 48'h0000_0000_0011, 7'd70, CHK_MODEL, no_echo));
		directed.push_back(req_row(1'b0, 48'h0, 7'd80, CHK_MODEL, no_echo));
		directed.push_back(req_row(1'b0, 48'h0000_5500_0000, 7'd90, CHK_MODEL, no_echo));
		directed.push_back(req_row(1'b1, 48'h0000_0000_0011, 7'd100, CHK_MODEL, no_echo));
		directed.push_back(req_row(1'b0, 48'h0, 7'd110, CHK_MODEL, no_echo));
		directed.push_back(req_row(1'b0, 48'h0000_6600_0000, 7'd120, CHK_MODEL, no_echo));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[k]) begin
			if (directed[k].kind == ROW_CFG) begin
				settle();
				write_reg(directed[k].addr, directed[k].val);
			end else begin
				send_req(directed[k].fp, directed[k].chunk, directed[k].req,
					directed[k].chk, directed[k].typed);
			end
		end

		for (phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 16 : (phase == 1) ? 84 : 0;
			for (s = 0; s < SETTINGS_PER_PHASE; s++) begin
				case ($urandom_range(3))
					0: lo_v = 7'd0;
					1: lo_v = 7'd127;
					2: lo_v = NODE_W'($urandom_range(127));
					default: lo_v = NODE_W'($urandom_range(20));
				endcase
				case ($urandom_range(3))
					0: hi_v = 7'd127;
					1: hi_v = 7'd1;
					2: hi_v = NODE_W'($urandom_range(1, 127));
					default: hi_v = NODE_W'($urandom_range(100, 127));
				endcase
				settle();
				write_reg(REG_LOWEST, lo_v);
				write_reg(REG_HIGHEST, hi_v);
				sent = 0;
				while (sent < REQS_PER_SETTING) begin
					r = $urandom_range(99);
					if (r < 75) begin
						// reuse ids often so matches and near misses are hit
						if (known_ids.size() != 0 && $urandom_range(99) < 40) begin
							uid = known_ids[$urandom_range(known_ids.size() - 1)];
							if ($urandom_range(2) == 0) begin
								flip = $urandom_range(127);
								uid[flip] = ~uid[flip];
							end
						end else begin
							uid = fresh_id();
							known_ids.push_back(uid);
						end
						run_handshake(uid, 3);
						sent += 3;
					end else if (r < 88) begin
						parts = $urandom_range(1, 2);
						run_handshake(fresh_id(), parts);
						sent += parts + 1;
					end else begin
						send_req(1'($urandom_range(1)), rand_chunk(), rand_node(),
							CHK_MODEL, no_echo);
						sent++;
					end
					if ($urandom_range(49) == 0)
						settle();
				end
			end
		end

		settle();
		if (mismatches == 0)
			$display("PASS node_id_allocation_server_top");
		else
			$display("FAIL node_id_allocation_server_top");
		$finish;
	end

endmodule
